// ===== rtl/mriqfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mriqfd_pkg
// Shared types and constants of the multi-receiver I/Q frame deframer.
// ----------------------------------------------------------------------------
package mriqfd_pkg;

    localparam int MAX_CHANNELS  = 8;
    localparam int FRAME_BYTES   = 512;
    localparam int PAYLOAD_BYTES = 504;
    localparam int HEADER_BYTES  = FRAME_BYTES - PAYLOAD_BYTES;
    localparam int MAX_DECIM     = 8;
    localparam int OUT_DEPTH_DEF = 4;

    // Sample sets per frame, indexed by channel count minus one.
    // A set is 6 bytes per channel plus a 2-byte mic word.
    localparam logic [5:0] SPF_TABLE [MAX_CHANNELS] = '{
        6'(PAYLOAD_BYTES / 8),  6'(PAYLOAD_BYTES / 14),
        6'(PAYLOAD_BYTES / 20), 6'(PAYLOAD_BYTES / 26),
        6'(PAYLOAD_BYTES / 32), 6'(PAYLOAD_BYTES / 38),
        6'(PAYLOAD_BYTES / 44), 6'(PAYLOAD_BYTES / 50)
    };

    typedef enum logic [1:0] {
        KIND_IQ   = 2'd0,
        KIND_MIC  = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_DDC_COUNT      = 2'd0,
        REG_MIC_DECIMATION = 2'd1,
        REG_FRAME_LIMIT    = 2'd2
    } reg_idx_t;

    // Results of one byte: an optional I/Q or mic result, then an optional
    // completion marker.
    typedef struct packed {
        logic        main_valid;
        kind_t       main_kind;
        logic [2:0]  channel;
        logic [31:0] i_value;
        logic [31:0] q_value;
        logic [25:0] sample_index;
        logic        marker;
    } out_entry_t;

endpackage : mriqfd_pkg
`default_nettype wire

// ===== rtl/multi_receiver_iq_frame_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_receiver_iq_frame_deframer
// Byte-stream deframer for multi-receiver I/Q and mic sample packets.
// ----------------------------------------------------------------------------
// Accepts one packet byte per clock while the result queue has room. Each byte
// is parsed by counter updates and a 40-bit shift, and its results go into
// an OUT_DEPTH-entry result queue, so input and output stall independently.
// A byte yields at most one I/Q or mic result, plus the completion marker on
// the last byte of a packet; that rare byte puts both on the result port in
// turn and the queue absorbs it. s_tready drops only when the queue is full.
// Registers (APB, 32-bit): 0x0 ddc_count, 0x4 mic_decimation, 0x8 frame_limit.
module multi_receiver_iq_frame_deframer #(
    parameter int OUT_DEPTH = mriqfd_pkg::OUT_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] packet_start
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // [2:0] channel, [34:3] i_value,
                                        // [66:35] q_value, [92:67] sample_index
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast,   // last_of_run
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mriqfd_pkg::*;

    localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    // ---------------- configuration ----------------
    logic [3:0]  ddc_reg;
    logic [3:0]  dec_reg;
    logic [19:0] limit_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ddc_reg   <= 4'd1;
            dec_reg   <= 4'd1;
            limit_reg <= 20'd0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DDC_COUNT:      ddc_reg   <= pwdata[3:0];
                REG_MIC_DECIMATION: dec_reg   <= pwdata[3:0];
                REG_FRAME_LIMIT:    limit_reg <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_DDC_COUNT:      prdata = {28'd0, ddc_reg};
            REG_MIC_DECIMATION: prdata = {28'd0, dec_reg};
            REG_FRAME_LIMIT:    prdata = {12'd0, limit_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // ---------------- parser state ----------------
    logic [9:0]  pos_reg,    pos_next;
    logic [5:0]  sbp_reg,    sbp_next;
    logic [5:0]  sif_reg,    sif_next;
    logic [39:0] asm_reg,    asm_next;
    logic [2:0]  mdc_reg,    mdc_next;
    logic [19:0] frames_reg, frames_next;
    logic [25:0] mics_reg,   mics_next;
    logic        done_reg,   done_next;

    logic        in_fire;
    logic [3:0]  nch;
    logic [3:0]  dec;
    logic [5:0]  spf;
    logic [5:0]  ch_bytes;
    logic [9:0]  pos;
    logic [8:0]  fpos;
    logic        frame_start;
    logic [5:0]  sbp_eff;
    logic [5:0]  sif_eff;
    logic [39:0] asm_eff;
    logic        capturing;
    logic        active;
    logic [11:0] div_prod;
    logic [2:0]  b_chan;
    logic [5:0]  b_rem;
    logic [25:0] set_idx;
    logic [39:0] asm_shift;
    out_entry_t  entry;

    always_comb begin
        if (ddc_reg == 4'd0)
            nch = 4'd1;
        else if (ddc_reg > 4'(MAX_CHANNELS))
            nch = 4'(MAX_CHANNELS);
        else
            nch = ddc_reg;
        if (dec_reg == 4'd0)
            dec = 4'd1;
        else if (dec_reg > 4'(MAX_DECIM))
            dec = 4'(MAX_DECIM);
        else
            dec = dec_reg;
    end

    assign spf      = SPF_TABLE[3'(nch - 4'd1)];
    assign ch_bytes = 6'(nch) * 6'd6;

    assign in_fire     = s_tvalid && s_tready;
    assign pos         = s_tuser ? 10'd0 : pos_reg;
    assign fpos        = pos[8:0];
    assign frame_start = (fpos == 9'd0);
    assign sbp_eff     = frame_start ? 6'd0  : sbp_reg;
    assign sif_eff     = frame_start ? 6'd0  : sif_reg;
    assign asm_eff     = frame_start ? 40'd0 : asm_reg;
    assign capturing   = (frames_reg < limit_reg);
    assign active      = capturing && (fpos >= 9'(HEADER_BYTES)) && (sif_eff < spf);

    // byte position / 6 by reciprocal multiply, exact for positions below 64
    assign div_prod  = {6'd0, sbp_eff} * 12'd43;
    assign b_chan    = div_prod[10:8];
    assign b_rem     = sbp_eff - 6'(b_chan) * 6'd6;
    assign set_idx   = 26'(frames_reg) * 26'(spf) + 26'(sif_eff);
    assign asm_shift = {asm_eff[31:0], s_tdata};

    always_comb begin
        sbp_next    = sbp_eff;
        sif_next    = sif_eff;
        asm_next    = asm_eff;
        mdc_next    = mdc_reg;
        frames_next = frames_reg;
        mics_next   = mics_reg;
        done_next   = done_reg;
        pos_next    = pos + 10'd1;

        entry              = '0;
        entry.main_kind    = KIND_IQ;
        entry.i_value      = {asm_eff[39:16], 8'd0};
        entry.q_value      = {asm_eff[15:0], s_tdata, 8'd0};
        entry.channel      = b_chan;
        entry.sample_index = set_idx;

        if (active) begin
            if (sbp_eff < ch_bytes) begin
                entry.main_valid = (b_rem == 6'd5);
                asm_next         = asm_shift;
                sbp_next         = sbp_eff + 6'd1;
            end else if (sbp_eff == ch_bytes) begin
                asm_next = asm_shift;
                sbp_next = sbp_eff + 6'd1;
            end else begin
                // second mic byte closes the set
                if (({1'b0, mdc_reg} + 4'd1) >= dec) begin
                    entry.main_valid   = 1'b1;
                    entry.main_kind    = KIND_MIC;
                    entry.channel      = 3'd0;
                    entry.i_value      = {asm_eff[7:0], s_tdata, 16'd0};
                    entry.q_value      = 32'd0;
                    entry.sample_index = mics_reg;
                    mics_next          = mics_reg + 26'd1;
                    mdc_next           = 3'd0;
                end else begin
                    mdc_next = mdc_reg + 3'd1;
                end
                asm_next = 40'd0;
                sbp_next = 6'd0;
                sif_next = sif_eff + 6'd1;
            end
        end

        if ((fpos == 9'(FRAME_BYTES - 1)) && capturing)
            frames_next = frames_reg + 20'd1;

        if ((pos == 10'(2 * FRAME_BYTES - 1)) && !done_reg && (frames_next >= limit_reg)) begin
            entry.marker = 1'b1;
            done_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            sbp_reg    <= '0;
            sif_reg    <= '0;
            asm_reg    <= '0;
            mdc_reg    <= '0;
            frames_reg <= '0;
            mics_reg   <= '0;
            done_reg   <= 1'b0;
        end else if (in_fire) begin
            pos_reg    <= pos_next;
            sbp_reg    <= sbp_next;
            sif_reg    <= sif_next;
            asm_reg    <= asm_next;
            mdc_reg    <= mdc_next;
            frames_reg <= frames_next;
            mics_reg   <= mics_next;
            done_reg   <= done_next;
        end
    end

    // ---------------- result queue ----------------
    out_entry_t       q_mem [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic             phase_reg,  phase_next;
    logic             push;
    logic             pop;
    logic             out_fire;
    logic             show_marker;
    out_entry_t       head;

    assign s_tready = (cnt_reg != CNT_W'(OUT_DEPTH));
    assign push     = in_fire && (entry.main_valid || entry.marker);
    assign head     = q_mem[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign out_fire = m_tvalid && m_tready;

    // marker goes out after the main result of the same byte
    assign show_marker = phase_reg || !head.main_valid;
    assign pop         = out_fire && (show_marker || !head.marker);

    always_comb begin
        if (show_marker) begin
            m_tuser = KIND_DONE;
            m_tdata = '0;
            m_tlast = 1'b1;
        end else begin
            m_tuser = head.main_kind;
            m_tdata = {3'd0, head.sample_index, head.q_value, head.i_value, head.channel};
            m_tlast = !head.marker;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        phase_next  = phase_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            phase_next  = 1'b0;
        end else if (out_fire) begin
            phase_next  = 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            phase_reg  <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            phase_reg  <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            q_mem[wr_ptr_reg] <= entry;
    end

endmodule : multi_receiver_iq_frame_deframer
`default_nettype wire

// ===== rtl/mriqfd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mriqfd_checker
// Port-level checks on the deframer result stream.
// ----------------------------------------------------------------------------
module mriqfd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);
    import mriqfd_pkg::*;

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // the completion marker always closes its run, with empty payload
    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_DONE) |-> (m_tlast && m_tdata == '0))
        else $error("completion marker malformed");

    // mic results carry no channel and no Q word
    a_mic_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_MIC) |-> (m_tdata[2:0] == 3'd0 && m_tdata[66:35] == 32'd0))
        else $error("mic transaction with channel or Q set");

    // stalled transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled transaction changed");

endmodule : mriqfd_checker

bind multi_receiver_iq_frame_deframer mriqfd_checker u_mriqfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
